@@ rtl/cchm_pkg.sv @@
// ----------------------------------------------------------------------------
// cchm_pkg: shared types and constants of the compass heading monitor
// Fixed-point format of the heading, mode and item codes, status bundle and
// the compass sector helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cchm_pkg;

   // Heading in 1/16 degree with extra fraction bits in the filter state.
   localparam int HEADING_FRAC_BITS = 8;
   localparam int HEAD_W            = 13;
   localparam int SMOOTH_W          = HEAD_W + HEADING_FRAC_BITS;
   localparam int DIFF_W            = SMOOTH_W + 1;
   localparam int SUM_W             = DIFF_W + 1;
   localparam int ALPHA_W           = 9;
   localparam int PROD_W            = DIFF_W + ALPHA_W + 1;
   localparam int ALPHA_SHIFT       = 8;

   localparam logic [HEAD_W-1:0] TURN_DEG16  = HEAD_W'(5760);
   localparam logic [13:0]       SECTOR_BIAS = 14'd360;
   localparam int                SECTOR_SPAN = 720;

   localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);

   localparam logic [1:0] CSR_ALPHA        = 2'd0;
   localparam logic [1:0] CSR_SAVE_HOLD    = 2'd1;
   localparam logic [1:0] CSR_WARN_CHECK   = 2'd2;
   localparam logic [1:0] CSR_WARN_DURATION = 2'd3;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET        = ALPHA_W'(26);
   localparam logic [15:0]        SAVE_HOLD_RESET    = 16'd3000;
   localparam logic [15:0]        WARN_CHECK_RESET   = 16'd500;
   localparam logic [31:0]        WARN_DURATION_RESET = 32'd10000;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_MANUAL = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_MANUAL = 2'd1,
      KIND_START  = 2'd2
   } kind_type;

   typedef struct packed {
      logic     fully_calibrated;
      logic     save_offsets;
      mode_type mode;
      logic     quality_warning;
   } mon_status_type;

   // Eight-way sector of a heading in 1/16 degree: floor((h + 22.5 deg) / 45 deg) mod 8.
   function automatic logic [2:0] sector_of(input logic [HEAD_W-1:0] head);
      logic [13:0] biased;
      logic [3:0]  count;
      biased = 14'(head) + SECTOR_BIAS;
      count  = 4'd0;
      for (int k = 1; k <= 8; k++) begin
         if (biased >= 14'(SECTOR_SPAN * k)) begin
            count = count + 4'd1;
         end
      end
      return count[2:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/cchm_filter.sv @@
// ----------------------------------------------------------------------------
// cchm_filter: circular exponential heading filter
// Holds the smoothed heading, steps it on sample items by alpha times the wrapped
// difference and reports the next heading and its compass sector.
// ----------------------------------------------------------------------------
`default_nettype none

module cchm_filter
   import cchm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                is_sample,
   input  wire logic [HEAD_W-1:0]   raw_heading,
   input  wire logic [ALPHA_W-1:0]  alpha_q8,
   output logic      [HEAD_W-1:0]   heading,
   output logic      [2:0]          direction
);

   localparam logic [SMOOTH_W-1:0]      TURN   = SMOOTH_W'(TURN_DEG16) << HEADING_FRAC_BITS;
   localparam logic signed [DIFF_W-1:0] TURN_D = DIFF_W'(TURN);
   localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(TURN >> 1);
   localparam logic signed [SUM_W-1:0]  TURN_S = SUM_W'(TURN);

   logic [SMOOTH_W-1:0]        smooth_ff;
   logic [SMOOTH_W-1:0]        smooth_in;
   logic [HEAD_W-1:0]          raw_wrap;
   logic signed [DIFF_W-1:0]   diff_raw;
   logic signed [DIFF_W-1:0]   diff_wrap;
   logic [ALPHA_W-1:0]         alpha_eff;
   logic signed [PROD_W-1:0]   product;
   logic signed [DIFF_W-1:0]   delta;
   logic signed [SUM_W-1:0]    sum_raw;
   logic signed [SUM_W-1:0]    sum_wrap;

   always_comb begin
      raw_wrap  = (raw_heading >= TURN_DEG16) ? raw_heading - TURN_DEG16 : raw_heading;
      diff_raw  = signed'({1'b0, raw_wrap, {HEADING_FRAC_BITS{1'b0}}})
                - signed'({1'b0, smooth_ff});
      // fold into half a turn each way; exactly half a turn stays
      if (diff_raw > HALF_D) begin
         diff_wrap = diff_raw - TURN_D;
      end else if (diff_raw < -HALF_D) begin
         diff_wrap = diff_raw + TURN_D;
      end else begin
         diff_wrap = diff_raw;
      end
      alpha_eff = (alpha_q8 > ALPHA_MAX) ? ALPHA_MAX : alpha_q8;
      product   = PROD_W'(signed'({1'b0, alpha_eff})) * PROD_W'(diff_wrap);
      // arithmetic shift rounds toward minus infinity
      delta     = DIFF_W'(product >>> ALPHA_SHIFT);
      sum_raw   = SUM_W'(signed'({1'b0, smooth_ff})) + SUM_W'(delta);
      if (sum_raw < 0) begin
         sum_wrap = sum_raw + TURN_S;
      end else if (sum_raw >= TURN_S) begin
         sum_wrap = sum_raw - TURN_S;
      end else begin
         sum_wrap = sum_raw;
      end
      smooth_in = is_sample ? SMOOTH_W'(sum_wrap) : smooth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
      end else if (step) begin
         smooth_ff <= smooth_in;
      end
   end

   assign heading   = smooth_in[SMOOTH_W-1 -: HEAD_W];
   assign direction = sector_of(smooth_in[SMOOTH_W-1 -: HEAD_W]);

endmodule

`default_nettype wire

@@ rtl/cchm_monitor.sv @@
// ----------------------------------------------------------------------------
// cchm_monitor: calibration timer, mode and quality warning
// Tracks how long full calibration has lasted, fires the save pulse, keeps
// the operating mode and evaluates the low quality warning at intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module cchm_monitor
   import cchm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [1:0]      kind,
   input  wire logic [1:0]      cal_sys,
   input  wire logic [1:0]      cal_gyro,
   input  wire logic [1:0]      cal_accel,
   input  wire logic [1:0]      cal_mag,
   input  wire logic [31:0]     now_ms,
   input  wire logic            stored_cal_valid,
   input  wire logic [15:0]     save_hold_ms,
   input  wire logic [15:0]     warning_check_ms,
   input  wire logic [31:0]     warning_duration_ms,
   output mon_status_type       status
);

   mode_type    mode_ff, mode_in;
   logic [31:0] stable_since_ff, stable_since_in;
   logic        stable_valid_ff, stable_valid_in;
   logic [31:0] last_check_ff, last_check_in;
   logic [31:0] low_since_ff, low_since_in;
   logic        low_valid_ff, low_valid_in;
   logic        warning_ff, warning_in;
   logic        full;
   logic        save;
   logic        low;
   logic [31:0] stable_since_t;
   logic [31:0] low_since_t;

   always_comb begin
      mode_in         = mode_ff;
      stable_since_in = stable_since_ff;
      stable_valid_in = stable_valid_ff;
      last_check_in   = last_check_ff;
      low_since_in    = low_since_ff;
      low_valid_in    = low_valid_ff;
      warning_in      = warning_ff;
      full            = 1'b0;
      save            = 1'b0;
      low             = (cal_sys < 2'd2) || (cal_mag < 2'd2);
      stable_since_t  = stable_since_ff;
      low_since_t     = low_since_ff;
      case (kind)
         KIND_SAMPLE: begin
            full = (cal_sys == 2'd3) && (cal_gyro == 2'd3)
                && (cal_accel == 2'd3) && (cal_mag == 2'd3);
            stable_since_t  = (full && !stable_valid_ff) ? now_ms : stable_since_ff;
            stable_since_in = stable_since_t;
            stable_valid_in = full;
            if (full && ((now_ms - stable_since_t) > 32'(save_hold_ms))) begin
               save            = 1'b1;
               mode_in         = MODE_NORMAL;
               stable_valid_in = 1'b0;
            end
            if ((now_ms - last_check_ff) >= 32'(warning_check_ms)) begin
               last_check_in = now_ms;
               if (mode_in == MODE_NORMAL && low) begin
                  low_since_t  = low_valid_ff ? low_since_ff : now_ms;
                  low_since_in = low_since_t;
                  low_valid_in = 1'b1;
                  if ((now_ms - low_since_t) > warning_duration_ms) begin
                     warning_in = 1'b1;
                  end
               end else begin
                  warning_in   = 1'b0;
                  low_valid_in = 1'b0;
               end
            end
         end
         KIND_MANUAL: begin
            mode_in = MODE_MANUAL;
         end
         KIND_START: begin
            if (!stored_cal_valid) begin
               mode_in = MODE_AUTO;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_NORMAL;
         stable_since_ff <= '0;
         stable_valid_ff <= 1'b0;
         last_check_ff   <= '0;
         low_since_ff    <= '0;
         low_valid_ff    <= 1'b0;
         warning_ff      <= 1'b0;
      end else if (step) begin
         mode_ff         <= mode_in;
         stable_since_ff <= stable_since_in;
         stable_valid_ff <= stable_valid_in;
         last_check_ff   <= last_check_in;
         low_since_ff    <= low_since_in;
         low_valid_ff    <= low_valid_in;
         warning_ff      <= warning_in;
      end
   end

   always_comb begin
      status.fully_calibrated = full;
      status.save_offsets     = save;
      status.mode             = mode_in;
      status.quality_warning  = warning_in;
   end

endmodule

`default_nettype wire

@@ rtl/compass_heading_calibration_monitor.sv @@
// ----------------------------------------------------------------------------
// compass_heading_calibration_monitor: heading smoother and calibration monitor
// Input register, one pass of filter and monitor logic, result register.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result side is not stalled and
// returns one result per item via the input and result registers. A single
// compute stage holds the 10 x 22 bit filter multiply, its wrap corrections
// and 32-bit timer compares; each item sees the state left by the one before
// it. csr_ready is always high; csr_ registers act on the next item; the user
// writes them only while no item is in flight; the block does not enforce it.
`default_nettype none

module compass_heading_calibration_monitor
   import cchm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   // input items
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [12:0]        req_raw_heading,
   input  wire logic [1:0]         req_cal_sys,
   input  wire logic [1:0]         req_cal_gyro,
   input  wire logic [1:0]         req_cal_accel,
   input  wire logic [1:0]         req_cal_mag,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic               req_stored_cal_valid,
   // results
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [12:0]             rsp_filtered_heading,
   output logic [2:0]              rsp_direction,
   output logic                    rsp_fully_calibrated,
   output logic                    rsp_save_offsets,
   output logic [1:0]              rsp_mode,
   output logic                    rsp_quality_warning
);

   logic [ALPHA_W-1:0] alpha_ff;
   logic [15:0]        save_hold_ff;
   logic [15:0]        warn_check_ff;
   logic [31:0]        warn_duration_ff;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         kind_ff;
   logic [12:0]        raw_ff;
   logic [1:0]         cal_sys_ff, cal_gyro_ff, cal_accel_ff, cal_mag_ff;
   logic [31:0]        now_ff;
   logic               stored_ff;

   logic               out_valid_ff, out_valid_in;
   logic [12:0]        heading_ff;
   logic [2:0]         direction_ff;
   mon_status_type     status_ff;

   logic               req_xfer;
   logic               advance;
   logic               load_out;
   logic [HEAD_W-1:0]  heading_next;
   logic [2:0]         direction_next;
   mon_status_type     status_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff         <= ALPHA_RESET;
         save_hold_ff     <= SAVE_HOLD_RESET;
         warn_check_ff    <= WARN_CHECK_RESET;
         warn_duration_ff <= WARN_DURATION_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA:         alpha_ff         <= csr_data[ALPHA_W-1:0];
            CSR_SAVE_HOLD:     save_hold_ff     <= csr_data[15:0];
            CSR_WARN_CHECK:    warn_check_ff    <= csr_data[15:0];
            CSR_WARN_DURATION: warn_duration_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // the result register frees up when empty or when its transfer completes
   assign advance   = !out_valid_ff || rsp_ready;
   assign load_out  = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (load_out) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff      <= req_kind;
         raw_ff       <= req_raw_heading;
         cal_sys_ff   <= req_cal_sys;
         cal_gyro_ff  <= req_cal_gyro;
         cal_accel_ff <= req_cal_accel;
         cal_mag_ff   <= req_cal_mag;
         now_ff       <= req_now_ms;
         stored_ff    <= req_stored_cal_valid;
      end
      if (load_out) begin
         heading_ff   <= heading_next;
         direction_ff <= direction_next;
         status_ff    <= status_next;
      end
   end

   cchm_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .step        (load_out),
      .is_sample   (kind_ff == KIND_SAMPLE),
      .raw_heading (raw_ff),
      .alpha_q8    (alpha_ff),
      .heading     (heading_next),
      .direction   (direction_next)
   );

   cchm_monitor u_monitor (
      .clock               (clock),
      .reset               (reset),
      .step                (load_out),
      .kind                (kind_ff),
      .cal_sys             (cal_sys_ff),
      .cal_gyro            (cal_gyro_ff),
      .cal_accel           (cal_accel_ff),
      .cal_mag             (cal_mag_ff),
      .now_ms              (now_ff),
      .stored_cal_valid    (stored_ff),
      .save_hold_ms        (save_hold_ff),
      .warning_check_ms    (warn_check_ff),
      .warning_duration_ms (warn_duration_ff),
      .status              (status_next)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_filtered_heading = heading_ff;
   assign rsp_direction        = direction_ff;
   assign rsp_fully_calibrated = status_ff.fully_calibrated;
   assign rsp_save_offsets     = status_ff.save_offsets;
   assign rsp_mode             = status_ff.mode;
   assign rsp_quality_warning  = status_ff.quality_warning;

`ifndef NO_ASSERTIONS
   a_save_normal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff.save_offsets |-> status_ff.mode == MODE_NORMAL)
      else $error("save pulse without normal mode");

   a_save_full: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff.save_offsets |-> status_ff.fully_calibrated)
      else $error("save pulse without full calibration");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> heading_ff < TURN_DEG16)
      else $error("filtered heading beyond one turn");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input held off without a stalled result");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("computed item did not reach the result register");
`endif

endmodule

`default_nettype wire
